FILE: rtl/dktq_pkg.sv
// Shared types, codes and helpers for the dual-key task queue.
// No dependencies; imported by every module of the block.
package dktq_pkg;

   localparam int CAPACITY_DEF = 64;

   // request kinds
   localparam logic [2:0] KIND_ADD      = 3'd0;
   localparam logic [2:0] KIND_EXEC     = 3'd1;
   localparam logic [2:0] KIND_NEXT     = 3'd2;
   localparam logic [2:0] KIND_PRINT    = 3'd3;
   localparam logic [2:0] KIND_CHG_PRI  = 3'd4;
   localparam logic [2:0] KIND_CHG_TIME = 3'd5;

   // response status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_EMPTY   = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_NOMATCH = 2'd3;

   localparam int SECS_W = 17;

   typedef struct packed {
      logic [2:0]  kind;
      logic        by_time;
      logic [6:0]  priority_req;
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
      logic [15:0] tag;
      logic [6:0]  new_priority;
      logic [4:0]  new_hours;
      logic [5:0]  new_minutes;
      logic [5:0]  new_seconds;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  out_priority;
      logic [4:0]  out_hours;
      logic [5:0]  out_minutes;
      logic [5:0]  out_seconds;
      logic [15:0] out_tag;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  pri;
      logic [4:0]  hh;
      logic [5:0]  mm;
      logic [5:0]  ss;
      logic [15:0] tg;
   } entry_type;

   typedef enum logic [1:0] {
      WR_SEL_REQ   = 2'd0,
      WR_SEL_CARRY = 2'd1,
      WR_SEL_RDATA = 2'd2,
      WR_SEL_PATCH = 2'd3
   } wr_sel_type;

   typedef struct packed {
      logic       req_load;
      logic       rd_en;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       carry_load;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       out_load;
      logic       out_entry;
      logic [1:0] out_status;
      logic       out_last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       out_busy;
      logic       keeps;
      logic       match;
   } sts_type;

   function automatic logic [SECS_W-1:0] arrival_secs(entry_type e);
      return SECS_W'(e.hh) * SECS_W'(3600) + SECS_W'(e.mm) * SECS_W'(60) + SECS_W'(e.ss);
   endfunction

endpackage

FILE: rtl/dktq_datapath.sv
// Datapath: request register, entry memory, carry register, entry count
// and response register. Depends on dktq_pkg.
module dktq_datapath import dktq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int IDX_W = $clog2(CAPACITY),
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_data,
   input  cmd_type          cmd,
   input  logic [IDX_W-1:0] rd_addr,
   input  logic [IDX_W-1:0] wr_addr,
   output sts_type          sts,
   output logic [CNT_W-1:0] count,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   entry_type        mem [CAPACITY];
   req_type          req_ff;
   entry_type        rd_data_ff;
   entry_type        carry_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   entry_type        wr_data;
   entry_type        patch;
   entry_type        req_entry;

   assign req_entry = '{pri: req_ff.priority_req, hh: req_ff.hours, mm: req_ff.minutes,
                        ss: req_ff.seconds, tg: req_ff.tag};

   always_comb begin
      patch = rd_data_ff;
      if (req_ff.kind == KIND_CHG_PRI) begin
         patch.pri = req_ff.new_priority;
      end else begin
         patch.hh = req_ff.new_hours;
         patch.mm = req_ff.new_minutes;
         patch.ss = req_ff.new_seconds;
      end
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_SEL_REQ:   wr_data = req_entry;
         WR_SEL_CARRY: wr_data = carry_ff;
         WR_SEL_RDATA: wr_data = rd_data_ff;
         WR_SEL_PATCH: wr_data = patch;
         default:      wr_data = rd_data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_data;
      end
      if (cmd.carry_load) begin
         carry_ff <= rd_data_ff;
      end
      if (cmd.out_load) begin
         rsp_ff.status       <= cmd.out_status;
         rsp_ff.out_priority <= cmd.out_entry ? rd_data_ff.pri : '0;
         rsp_ff.out_hours    <= cmd.out_entry ? rd_data_ff.hh  : '0;
         rsp_ff.out_minutes  <= cmd.out_entry ? rd_data_ff.mm  : '0;
         rsp_ff.out_seconds  <= cmd.out_entry ? rd_data_ff.ss  : '0;
         rsp_ff.out_tag      <= cmd.out_entry ? rd_data_ff.tg  : '0;
         rsp_ff.last         <= cmd.out_last;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - 1'b1;
      end
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.kind     = req_ff.kind;
   assign sts.out_busy = rsp_valid_ff & rsp_stall;
   assign sts.keeps    = req_ff.by_time ? (arrival_secs(carry_ff) <= arrival_secs(rd_data_ff))
                                        : (carry_ff.pri >= rd_data_ff.pri);
   assign sts.match    = (req_ff.kind == KIND_CHG_PRI)
                         ? (rd_data_ff.pri == req_ff.priority_req)
                         : (rd_data_ff.hh == req_ff.hours && rd_data_ff.mm == req_ff.minutes
                            && rd_data_ff.ss == req_ff.seconds);

   assign count     = count_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall)) else $error("response overwritten");
   a_inc_room: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> count_ff < CNT_W'(CAPACITY)) else $error("add past capacity");
   a_dec_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |-> count_ff != '0) else $error("remove from empty table");
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (CNT_W'(wr_addr) < count_ff
                     || (cmd.wr_sel == WR_SEL_REQ && CNT_W'(wr_addr) == count_ff)))
      else $error("write outside live entries");

endmodule

FILE: rtl/dktq_ctrl.sv
// Controller: sequences add, sort passes, output, shift-out and change scans.
// Depends on dktq_pkg.
module dktq_ctrl import dktq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int IDX_W = $clog2(CAPACITY),
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sts_type          sts,
   input  logic [CNT_W-1:0] count,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] rd_addr,
   output logic [IDX_W-1:0] wr_addr
);

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_DECODE   = 13'b0000000000010,
      ST_SORT_RD0 = 13'b0000000000100,
      ST_SORT_LD  = 13'b0000000001000,
      ST_SORT_RD  = 13'b0000000010000,
      ST_SORT_CMP = 13'b0000000100000,
      ST_SORT_END = 13'b0000001000000,
      ST_OUT_RD   = 13'b0000010000000,
      ST_OUT_WAIT = 13'b0000100000000,
      ST_SHIFT_RD = 13'b0001000000000,
      ST_SHIFT_WR = 13'b0010000000000,
      ST_SCAN_RD  = 13'b0100000000000,
      ST_SCAN_CMP = 13'b1000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic             emit_ff, emit_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             swapped_ff, swapped_in;
   logic [1:0]       status_ff, status_in;
   logic [CNT_W-1:0] cnt_m1;
   logic             idx_last;

   assign cnt_m1   = count - 1'b1;
   assign idx_last = (CNT_W'(idx_ff) == cnt_m1);

   always_comb begin
      cmd        = '0;
      cmd.wr_sel = WR_SEL_RDATA;
      rd_addr    = idx_ff;
      wr_addr    = idx_ff;
      state_in   = state_ff;
      emit_in    = emit_ff;
      idx_in     = idx_ff;
      swapped_in = swapped_ff;
      status_in  = status_ff;

      if (emit_ff) begin
         // single status-only response, then back to idle
         if (!sts.out_busy) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = status_ff;
            cmd.out_last   = 1'b1;
            emit_in        = 1'b0;
            state_in       = ST_IDLE;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd.req_load = 1'b1;
                  state_in     = ST_DECODE;
               end
            end
            ST_DECODE: begin
               idx_in = '0;
               case (sts.kind)
                  KIND_ADD: begin
                     emit_in = 1'b1;
                     if (count == CNT_W'(CAPACITY)) begin
                        status_in = STAT_FULL;
                     end else begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = WR_SEL_REQ;
                        wr_addr     = IDX_W'(count);
                        cmd.cnt_inc = 1'b1;
                        status_in   = STAT_OK;
                     end
                  end
                  KIND_EXEC, KIND_NEXT, KIND_PRINT: begin
                     if (count == '0) begin
                        status_in = STAT_EMPTY;
                        emit_in   = 1'b1;
                     end else if (count == CNT_W'(1)) begin
                        state_in = ST_OUT_RD;
                     end else begin
                        swapped_in = 1'b0;
                        state_in   = ST_SORT_RD0;
                     end
                  end
                  KIND_CHG_PRI, KIND_CHG_TIME: begin
                     if (count == '0) begin
                        status_in = STAT_NOMATCH;
                        emit_in   = 1'b1;
                     end else begin
                        state_in = ST_SCAN_RD;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
            ST_SORT_RD0: begin
               cmd.rd_en = 1'b1;
               rd_addr   = '0;
               state_in  = ST_SORT_LD;
            end
            ST_SORT_LD: begin
               cmd.carry_load = 1'b1;
               idx_in         = IDX_W'(1);
               state_in       = ST_SORT_RD;
            end
            ST_SORT_RD: begin
               cmd.rd_en = 1'b1;
               state_in  = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
               cmd.wr_en = 1'b1;
               wr_addr   = idx_ff - 1'b1;
               if (sts.keeps) begin
                  cmd.wr_sel     = WR_SEL_CARRY;
                  cmd.carry_load = 1'b1;
               end else begin
                  cmd.wr_sel = WR_SEL_RDATA;
                  swapped_in = 1'b1;
               end
               if (idx_last) begin
                  state_in = ST_SORT_END;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SORT_RD;
               end
            end
            ST_SORT_END: begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_SEL_CARRY;
               wr_addr    = IDX_W'(cnt_m1);
               swapped_in = 1'b0;
               if (swapped_ff) begin
                  state_in = ST_SORT_RD0;
               end else begin
                  idx_in   = '0;
                  state_in = ST_OUT_RD;
               end
            end
            ST_OUT_RD: begin
               cmd.rd_en = 1'b1;
               state_in  = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
               if (!sts.out_busy) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_entry  = 1'b1;
                  cmd.out_status = STAT_OK;
                  cmd.out_last   = (sts.kind != KIND_PRINT) || idx_last;
                  state_in       = ST_IDLE;
                  if (sts.kind == KIND_PRINT && !idx_last) begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = ST_OUT_RD;
                  end else if (sts.kind == KIND_EXEC) begin
                     if (count == CNT_W'(1)) begin
                        cmd.cnt_dec = 1'b1;
                     end else begin
                        idx_in   = IDX_W'(1);
                        state_in = ST_SHIFT_RD;
                     end
                  end
               end
            end
            ST_SHIFT_RD: begin
               cmd.rd_en = 1'b1;
               state_in  = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_SEL_RDATA;
               wr_addr    = idx_ff - 1'b1;
               if (idx_last) begin
                  cmd.cnt_dec = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SHIFT_RD;
               end
            end
            ST_SCAN_RD: begin
               cmd.rd_en = 1'b1;
               state_in  = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
               if (sts.match) begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = WR_SEL_PATCH;
                  status_in  = STAT_OK;
                  emit_in    = 1'b1;
               end else if (idx_last) begin
                  status_in = STAT_NOMATCH;
                  emit_in   = 1'b1;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SCAN_RD;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         emit_ff    <= 1'b0;
         swapped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         emit_ff    <= emit_in;
         swapped_ff <= swapped_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      status_ff <= status_in;
   end

   assign req_stall = (state_ff != ST_IDLE) || emit_ff;

endmodule

FILE: rtl/dual_key_task_queue_core.sv
// Add stores the entry; change scans from position 0 to the first match; exec,
// next and print sort by bubble passes, at most n passes for n entries, then
// return entries; exec then shifts the remaining entries down. The core takes one
// item at a time: a new request is stalled until the last one is done. Reset is
// synchronous; it empties the table. Depends on dktq_pkg, dktq_datapath, dktq_ctrl.
module dual_key_task_queue_core import dktq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   cmd_type          cmd;
   sts_type          sts;
   logic [CNT_W-1:0] count;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;

   // sequence each transfer: decode, sort, emit results, compact the table
   dktq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .count     (count),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr)
   );

   // hold entries, compare keys, drive the response register
   dktq_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .sts       (sts),
      .count     (count),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
